@@ design/quaternion_to_axis_angle_macros.svh @@
// Assertion macros for the quaternion to axis-angle converter.
// Used by the top level; no other dependencies.
`ifndef QUATERNION_TO_AXIS_ANGLE_MACROS_SVH
`define QUATERNION_TO_AXIS_ANGLE_MACROS_SVH
`ifndef SYNTH
`define Q2A_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("q2a check failed");
`define Q2A_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("q2a check failed");
`else
`define Q2A_ASSERT_IMPL(lbl, ante, cons)
`define Q2A_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ design/q2a_pkg.sv @@
// Package for the quaternion to axis-angle converter: types, constants, tables.
// No dependencies.
package q2a_pkg;
  localparam int COMP_WIDTH_DEF = 16;
  localparam int QW = 16;
  localparam int AW = 15;
  localparam int THR_W = 10;
  localparam logic [THR_W-1:0] THR_RESET = 10'd2;
  localparam logic [AW-1:0] ANGLE_MAX = 15'd25736;

  typedef struct packed {
    logic signed [QW-1:0] quat_x;
    logic signed [QW-1:0] quat_y;
    logic signed [QW-1:0] quat_z;
    logic signed [QW-1:0] quat_w;
  } quat_t;

  typedef struct packed {
    logic signed [QW-1:0] axis_x;
    logic signed [QW-1:0] axis_y;
    logic signed [QW-1:0] axis_z;
    logic [AW-1:0]        rot_angle;
    logic                 degenerate;
  } axang_t;

  function automatic logic [19:0] atan_tab(input int i);
    case (i)
      0: atan_tab = 20'd823550;
      1: atan_tab = 20'd486170;
      2: atan_tab = 20'd256879;
      3: atan_tab = 20'd130396;
      4: atan_tab = 20'd65451;
      5: atan_tab = 20'd32757;
      6: atan_tab = 20'd16383;
      7: atan_tab = 20'd8192;
      8: atan_tab = 20'd4096;
      9: atan_tab = 20'd2048;
      10: atan_tab = 20'd1024;
      11: atan_tab = 20'd512;
      12: atan_tab = 20'd256;
      13: atan_tab = 20'd128;
      14: atan_tab = 20'd64;
      15: atan_tab = 20'd32;
      16: atan_tab = 20'd16;
      17: atan_tab = 20'd8;
      18: atan_tab = 20'd4;
      19: atan_tab = 20'd2;
      20: atan_tab = 20'd1;
      default: atan_tab = 20'd0;
    endcase
  endfunction
endpackage

@@ design/q2a_if.sv @@
// Valid/ready channel interface carrying one beat of payload.
// Generic over the payload type; no package dependency.
interface q2a_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/q2a_sqrt.sv @@
// Pipelined integer square root, one result bit per stage, plus side payload.
// No dependencies.
module q2a_sqrt #(
  parameter int SW = 34,
  parameter int RW = 17,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [SW-1:0] in_s,
  input  logic [PW-1:0] in_pay,
  output logic          out_vld,
  output logic [RW-1:0] out_root,
  output logic [PW-1:0] out_pay
);
  logic [RW:0]           vld_r;
  logic [RW:0][2*RW-1:0] rem_r;
  logic [RW:0][RW-1:0]   root_r;
  logic [RW:0][PW-1:0]   pay_r;

  always_comb begin
    vld_r[0]  = in_vld;
    rem_r[0]  = (2*RW)'(in_s);
    root_r[0] = '0;
    pay_r[0]  = in_pay;
  end

  for (genvar g = 0; g < RW; g++) begin : g_st
    localparam int B = RW - 1 - g;
    logic [2*RW+1:0] trial;
    logic [2*RW+1:0] remw;
    assign remw  = (2*RW+2)'(rem_r[g]);
    assign trial = ((2*RW+2)'(root_r[g]) << (B + 1)) | ((2*RW+2)'(1) << (2*B));
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else if (en) begin
        vld_r[g+1] <= vld_r[g];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        pay_r[g+1] <= pay_r[g];
        if (remw >= trial) begin
          rem_r[g+1]  <= (2*RW)'(remw - trial);
          root_r[g+1] <= root_r[g] | (RW'(1) << B);
        end else begin
          rem_r[g+1]  <= rem_r[g];
          root_r[g+1] <= root_r[g];
        end
      end
    end
  end

  assign out_vld  = vld_r[RW];
  assign out_root = root_r[RW];
  assign out_pay  = pay_r[RW];
endmodule

@@ design/q2a_div.sv @@
// Pipelined restoring divider: q = (mag*2^15 + m) / (2m), one quotient bit per stage.
// No dependencies.
module q2a_div #(
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [15:0]   in_mag,
  input  logic [16:0]   in_m,
  input  logic [PW-1:0] in_pay,
  output logic          out_vld,
  output logic [31:0]   out_q,
  output logic [PW-1:0] out_pay
);
  localparam int NW = 32;
  localparam int DW = 18;
  logic [NW:0]           vld_r;
  logic [NW:0][NW-1:0]   num_r;
  logic [NW:0][DW:0]     rem_r;
  logic [NW:0][DW-1:0]   den_r;
  logic [NW:0][PW-1:0]   pay_r;

  always_comb begin
    vld_r[0] = in_vld;
    num_r[0] = (NW'(in_mag) << 15) + NW'(in_m);
    rem_r[0] = '0;
    den_r[0] = {in_m, 1'b0};
    pay_r[0] = in_pay;
  end

  for (genvar g = 0; g < NW; g++) begin : g_st
    logic [DW:0] sh;
    assign sh = {rem_r[g][DW-1:0], num_r[g][NW-1]};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else if (en) begin
        vld_r[g+1] <= vld_r[g];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        pay_r[g+1] <= pay_r[g];
        den_r[g+1] <= den_r[g];
        if (sh >= {1'b0, den_r[g]}) begin
          rem_r[g+1] <= sh - {1'b0, den_r[g]};
          num_r[g+1] <= {num_r[g][NW-2:0], 1'b1};
        end else begin
          rem_r[g+1] <= sh;
          num_r[g+1] <= {num_r[g][NW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_vld = vld_r[NW];
  assign out_q   = num_r[NW];
  assign out_pay = pay_r[NW];
endmodule

@@ design/q2a_cordic.sv @@
// Pipelined CORDIC vectoring stages giving atan2(y, x) in 2^-20 rad.
// Depends on q2a_pkg for the arctangent table.
module q2a_cordic #(
  parameter int COMP_WIDTH = q2a_pkg::COMP_WIDTH_DEF,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [16:0]   in_y,
  input  logic [15:0]   in_x,
  input  logic [PW-1:0] in_pay,
  output logic          out_vld,
  output logic signed [23:0] out_z,
  output logic [PW-1:0] out_pay
);
  localparam int N  = (COMP_WIDTH > 32) ? 32 : COMP_WIDTH;
  localparam int XW = 33;
  logic [N:0]                    vld_r;
  logic signed [N:0][XW-1:0]     x_r;
  logic signed [N:0][XW-1:0]     y_r;
  logic signed [N:0][23:0]       z_r;
  logic [N:0][PW-1:0]            pay_r;

  always_comb begin
    vld_r[0] = in_vld;
    x_r[0]   = XW'({in_x, 12'd0});
    y_r[0]   = XW'({in_y, 12'd0});
    z_r[0]   = '0;
    pay_r[0] = in_pay;
  end

  for (genvar g = 0; g < N; g++) begin : g_st
    logic signed [XW-1:0] dx, dy, xs, ys;
    logic signed [23:0] at;
    assign xs = x_r[g];
    assign ys = y_r[g];
    assign dx = ys >>> g;
    assign dy = xs >>> g;
    assign at = 24'(q2a_pkg::atan_tab(g));
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else if (en) begin
        vld_r[g+1] <= vld_r[g];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        pay_r[g+1] <= pay_r[g];
        if (ys > 0) begin
          x_r[g+1] <= xs + dx;
          y_r[g+1] <= ys - dy;
          z_r[g+1] <= $signed(z_r[g]) + at;
        end else begin
          x_r[g+1] <= xs - dx;
          y_r[g+1] <= ys + dy;
          z_r[g+1] <= $signed(z_r[g]) - at;
        end
      end
    end
  end

  assign out_vld = vld_r[N];
  assign out_z   = z_r[N];
  assign out_pay = pay_r[N];
endmodule

@@ design/quaternion_to_axis_angle.sv @@
// Top level of the quaternion to axis-angle converter: sqrt, divide, CORDIC, skid.
// Depends on q2a_pkg, q2a_if, q2a_sqrt, q2a_div, q2a_cordic and the macros header.
//
//  channel | dir | payload
//  in_     | in  | quat_x, quat_y, quat_z, quat_w
//  out_    | out | axis_x, axis_y, axis_z, rot_angle, degenerate
//  cfg_    | in  | zero_threshold (10 bits)
//
// One beat per cycle while the skid stage is empty; the sqrt, divide and CORDIC pipelines are in series.
// The whole pipeline advances together; a stall holds every stage.
// Reset clears all valid bits and sets the threshold to 2.
`include "quaternion_to_axis_angle_macros.svh"
module quaternion_to_axis_angle #(
  parameter int COMP_WIDTH = q2a_pkg::COMP_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  q2a_if.sink   in_ch,
  q2a_if.source out_ch,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [q2a_pkg::THR_W-1:0] cfg_zero_threshold
);
  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vz;
    logic signed [15:0] w;
  } p1_t;
  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vz;
    logic               neg;
    logic               degen;
    logic [16:0]        m;
    logic [15:0]        aw;
  } p2_t;
  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic               degen;
  } p4_t;

  logic [q2a_pkg::THR_W-1:0] thr_r;
  logic en;
  logic pipe_vld;
  q2a_pkg::axang_t res;
  logic skid_vld_r, out_vld_r;
  q2a_pkg::axang_t skid_r, out_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= q2a_pkg::THR_RESET;
    end else if (cfg_valid) begin
      thr_r <= cfg_zero_threshold;
    end
  end

  assign en = !skid_vld_r;
  assign in_ch.ready = en;

  logic [33:0] s;
  logic signed [31:0] sq_x, sq_y, sq_z;
  p1_t p1;
  always_comb begin
    sq_x = $signed(in_ch.data.quat_x) * $signed(in_ch.data.quat_x);
    sq_y = $signed(in_ch.data.quat_y) * $signed(in_ch.data.quat_y);
    sq_z = $signed(in_ch.data.quat_z) * $signed(in_ch.data.quat_z);
    s = 34'(sq_x) + 34'(sq_y) + 34'(sq_z);
    p1 = '{in_ch.data.quat_x, in_ch.data.quat_y, in_ch.data.quat_z, in_ch.data.quat_w};
  end

  logic in_vld_r;
  logic [33:0] s_r;
  p1_t p1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (en) begin
      in_vld_r <= in_ch.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s_r  <= s;
      p1_r <= p1;
    end
  end

  logic sq_vld;
  logic [16:0] m;
  p1_t sq_p;
  q2a_sqrt #(.SW(34), .RW(17), .PW($bits(p1_t))) u_sqrt (
    .clk, .rst_n, .en, .in_vld(in_vld_r), .in_s(s_r), .in_pay(p1_r),
    .out_vld(sq_vld), .out_root(m), .out_pay(sq_p)
  );

  p2_t p2;
  logic [15:0] mag_x, mag_y, mag_z;
  always_comb begin
    p2.vx    = sq_p.vx;
    p2.vy    = sq_p.vy;
    p2.vz    = sq_p.vz;
    p2.neg   = sq_p.w[15];
    p2.degen = (m == '0) || (m < 17'(thr_r));
    p2.m     = m;
    p2.aw    = sq_p.w[15] ? 16'(-sq_p.w) : sq_p.w;
    mag_x    = sq_p.vx[15] ? 16'(-sq_p.vx) : sq_p.vx;
    mag_y    = sq_p.vy[15] ? 16'(-sq_p.vy) : sq_p.vy;
    mag_z    = sq_p.vz[15] ? 16'(-sq_p.vz) : sq_p.vz;
  end

  logic dv_x, dv_y, dv_z;
  logic [31:0] qx, qy, qz;
  p2_t dp;
  logic [16:0] dm;
  assign dm = (m == '0) ? 17'd1 : m;
  q2a_div #(.PW($bits(p2_t))) u_div_x (
    .clk, .rst_n, .en, .in_vld(sq_vld), .in_mag(mag_x), .in_m(dm), .in_pay(p2),
    .out_vld(dv_x), .out_q(qx), .out_pay(dp)
  );
  q2a_div #(.PW(1)) u_div_y (
    .clk, .rst_n, .en, .in_vld(sq_vld), .in_mag(mag_y), .in_m(dm), .in_pay(1'b0),
    .out_vld(dv_y), .out_q(qy), .out_pay()
  );
  q2a_div #(.PW(1)) u_div_z (
    .clk, .rst_n, .en, .in_vld(sq_vld), .in_mag(mag_z), .in_m(dm), .in_pay(1'b0),
    .out_vld(dv_z), .out_q(qz), .out_pay()
  );

  function automatic logic signed [15:0] axc(input logic signed [15:0] v,
                                            input logic [31:0] q,
                                            input logic degen, input logic neg);
    logic signed [33:0] a;
    begin
      a = degen ? 34'(v) : (v[15] ? -$signed({2'b0, q}) : $signed({2'b0, q}));
      if (neg) a = -a;
      if (a > 34'sd32767) axc = 16'sh7fff;
      else if (a < -34'sd32768) axc = 16'sh8000;
      else axc = a[15:0];
    end
  endfunction

  p4_t p4;
  always_comb begin
    p4.ax    = axc(dp.vx, qx, dp.degen, dp.neg);
    p4.ay    = axc(dp.vy, qy, dp.degen, dp.neg);
    p4.az    = axc(dp.vz, qz, dp.degen, dp.neg);
    p4.degen = dp.degen;
  end

  logic signed [23:0] z;
  p4_t cp;
  q2a_cordic #(.COMP_WIDTH(COMP_WIDTH), .PW($bits(p4_t))) u_cordic (
    .clk, .rst_n, .en, .in_vld(dv_x), .in_y(dp.m), .in_x(dp.aw), .in_pay(p4),
    .out_vld(pipe_vld), .out_z(z), .out_pay(cp)
  );

  logic signed [25:0] ang;
  always_comb begin
    ang = (26'(z) * 26'sd2 + 26'sd64) >>> 7;
    res.axis_x = cp.ax;
    res.axis_y = cp.ay;
    res.axis_z = cp.az;
    res.degenerate = cp.degen;
    if (cp.degen || ang < 0) res.rot_angle = '0;
    else if (ang > 26'(q2a_pkg::ANGLE_MAX)) res.rot_angle = q2a_pkg::ANGLE_MAX;
    else res.rot_angle = ang[14:0];
  end

  // output register plus skid stage; hold the pipeline while the skid is full
  logic out_take;
  assign out_take = !out_vld_r || out_ch.ready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (out_take) begin
        out_vld_r  <= skid_vld_r || (pipe_vld && en);
        skid_vld_r <= 1'b0;
      end else if (pipe_vld && en) begin
        skid_vld_r <= 1'b1;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (out_take) begin
      out_r <= skid_vld_r ? skid_r : res;
    end else if (pipe_vld && en) begin
      skid_r <= res;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_r;

  `Q2A_ASSERT_IMPL(a_skid_only_when_stalled, skid_vld_r, out_vld_r)
  `Q2A_ASSERT_IMPL(a_angle_range, out_vld_r, out_r.rot_angle <= q2a_pkg::ANGLE_MAX)
  `Q2A_ASSERT_IMPL(a_degen_zero_angle, out_vld_r && out_r.degenerate, out_r.rot_angle == '0)
  `Q2A_ASSERT_NEXT(a_div_lanes_aligned, 1'b1, dv_x == dv_y && dv_x == dv_z)
endmodule
